[hw/rtl/aupc_pkg.sv]
package aupc_pkg;

   // Color channel lanes inside the pipeline payload.
   localparam int ChanRed   = 0;
   localparam int ChanGreen = 1;
   localparam int ChanBlue  = 2;
   localparam int ChanCount = 3;

   // Quotient bits resolved by each divider stage; two stages give eight bits.
   localparam int DivStepsPerStage = 4;

   // Register file.
   localparam int          CsrAddrWidth   = 3;
   localparam logic        RegKeepAlpha   = 1'b0;  // word index of keep_alpha
   localparam logic        KeepAlphaReset = 1'b1;
   localparam logic [7:0]  ColorMax       = 8'hFF;

   // One color lane of the divider: partial remainder, numerator bits not yet
   // shifted in, quotient bits so far, saturation flag and the raw byte.
   typedef struct packed {
      logic [7:0] rem;
      logic [7:0] num_lo;
      logic [7:0] quo;
      logic       sat;
      logic [7:0] raw;
   } chan_type;

   typedef struct packed {
      logic                       keep;
      logic                       zero;
      logic [7:0]                 alpha;
      logic                       row_end;
      logic                       frame_end;
      chan_type [ChanCount-1:0]   chan;
   } pipe_type;

endpackage

[hw/rtl/aupc_front.sv]
module aupc_front
   import aupc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [31:0] pixel_word,
   input  logic        row_end,
   input  logic        frame_end,
   input  logic        keep,
   output logic        out_valid,
   input  logic        out_ready,
   output pipe_type    out_data
);

   logic     valid_ff, valid_in;
   pipe_type data_ff, data_in;
   logic [7:0] alpha;

   assign alpha = pixel_word[31:24];

   // Numerator c*255 + a/2 fits 16 bits; the high byte is the starting
   // remainder and also decides whether the quotient exceeds 255.
   always_comb begin
      logic [7:0]  c;
      logic [15:0] numer;
      data_in.keep      = keep;
      data_in.zero      = (alpha == 8'h00);
      data_in.alpha     = alpha;
      data_in.row_end   = row_end;
      data_in.frame_end = frame_end;
      for (int i = 0; i < ChanCount; i++) begin
         c     = pixel_word[8*i +: 8];
         numer = {c, 8'h00} - {8'h00, c} + {9'h000, alpha[7:1]};
         data_in.chan[ChanCount-1-i].raw    = c;
         data_in.chan[ChanCount-1-i].rem    = numer[15:8];
         data_in.chan[ChanCount-1-i].num_lo = numer[7:0];
         data_in.chan[ChanCount-1-i].quo    = 8'h00;
         data_in.chan[ChanCount-1-i].sat    = (numer[15:8] >= alpha);
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[hw/rtl/aupc_div_stage.sv]
module aupc_div_stage
   import aupc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  pipe_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output pipe_type out_data
);

   logic     valid_ff, valid_in;
   pipe_type data_ff, data_in;

   // Restoring division, one quotient bit per step. For an item that does not
   // saturate the remainder stays below alpha, so it always fits a byte after each step.
   always_comb begin
      logic [8:0] rem9;
      logic       ge;
      data_in = in_data;
      for (int ch = 0; ch < ChanCount; ch++) begin
         for (int s = 0; s < DivStepsPerStage; s++) begin
            rem9 = {data_in.chan[ch].rem, data_in.chan[ch].num_lo[7]};
            ge   = (rem9 >= {1'b0, in_data.alpha});
            data_in.chan[ch].rem    = ge ? 8'(rem9 - {1'b0, in_data.alpha}) : rem9[7:0];
            data_in.chan[ch].num_lo = {data_in.chan[ch].num_lo[6:0], 1'b0};
            data_in.chan[ch].quo    = {data_in.chan[ch].quo[6:0], ge};
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[hw/rtl/argb_unpremultiply_convert_top.sv]
// Channel  | Direction | Handshake             | Contents
// req      | in        | req_valid / req_ready | premultiplied ARGB32 word, row and frame ends
// rsp      | out       | rsp_valid / rsp_ready | red, green, blue, alpha bytes, row and frame ends
// csr      | in/out    | APB, pready always 1  | keep_alpha at byte address 0
//
// One item enters per clock while rsp_ready is high; the pipeline then sustains one
// item per cycle. From acceptance to rsp_valid an item passes the numerator stage,
// loaded at the accepting edge, then two divider stages of four quotient bits each,
// then the output register.
// Reset is synchronous and active high; it empties the pipeline and sets
// keep_alpha to 1. Each stage has its own valid bit and takes a new item when
// it is empty or its successor takes its item, so a stall at rsp holds every
// item in place and bubbles close up.
module argb_unpremultiply_convert_top
   import aupc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [31:0]             req_pixel_word,
   input  logic                    req_row_end_in,
   input  logic                    req_frame_end_in,

   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_red_out,
   output logic [7:0]              rsp_green_out,
   output logic [7:0]              rsp_blue_out,
   output logic [7:0]              rsp_alpha_out,
   output logic                    rsp_row_end_out,
   output logic                    rsp_frame_end_out,

   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   // Configuration register. The word index is the address above the byte
   // offset; writes to any other word are dropped.
   logic keep_alpha_ff, keep_alpha_in;
   logic csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CsrAddrWidth-1:2] == RegKeepAlpha);

   always_comb begin
      keep_alpha_in = keep_alpha_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         keep_alpha_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_alpha_ff <= KeepAlphaReset;
      end else begin
         keep_alpha_ff <= keep_alpha_in;
      end
   end

   assign csr_prdata = csr_hit ? {31'h0, keep_alpha_ff} : 32'h0;

   // Pipeline stages. The mode bit is captured with each item at entry.
   logic     front_valid, front_ready;
   pipe_type front_data;
   logic     div0_valid, div0_ready;
   pipe_type div0_data;
   logic     div1_valid, div1_ready;
   pipe_type div1_data;

   aupc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .pixel_word (req_pixel_word),
      .row_end    (req_row_end_in),
      .frame_end  (req_frame_end_in),
      .keep       (keep_alpha_ff),
      .out_valid  (front_valid),
      .out_ready  (front_ready),
      .out_data   (front_data)
   );

   aupc_div_stage u_div_hi (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (div0_valid),
      .out_ready (div0_ready),
      .out_data  (div0_data)
   );

   aupc_div_stage u_div_lo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div0_valid),
      .in_ready  (div0_ready),
      .in_data   (div0_data),
      .out_valid (div1_valid),
      .out_ready (div1_ready),
      .out_data  (div1_data)
   );

   // Output register. In alpha mode a zero alpha gives black, and a color
   // byte above alpha saturates to full scale; otherwise the quotient is used.
   // In plain mode the raw color bytes pass and alpha reads as zero.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] color_ff [ChanCount];
   logic [7:0] color_in [ChanCount];
   logic [7:0] alpha_ff, alpha_in;
   logic       row_end_ff, frame_end_ff;
   logic       keep_ff;

   always_comb begin
      for (int ch = 0; ch < ChanCount; ch++) begin
         if (!div1_data.keep) begin
            color_in[ch] = div1_data.chan[ch].raw;
         end else if (div1_data.zero) begin
            color_in[ch] = 8'h00;
         end else if (div1_data.chan[ch].sat) begin
            color_in[ch] = ColorMax;
         end else begin
            color_in[ch] = div1_data.chan[ch].quo;
         end
      end
      alpha_in = div1_data.keep ? div1_data.alpha : 8'h00;
   end

   assign div1_ready   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = div1_ready ? div1_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (div1_valid && div1_ready) begin
         color_ff     <= color_in;
         alpha_ff     <= alpha_in;
         row_end_ff   <= div1_data.row_end;
         frame_end_ff <= div1_data.frame_end;
         keep_ff      <= div1_data.keep;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_red_out       = color_ff[ChanRed];
   assign rsp_green_out     = color_ff[ChanGreen];
   assign rsp_blue_out      = color_ff[ChanBlue];
   assign rsp_alpha_out     = alpha_ff;
   assign rsp_row_end_out   = row_end_ff;
   assign rsp_frame_end_out = frame_end_ff;

   // Reset empties the pipeline, so nothing is offered right after it.
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered in the cycle after reset");

   // With the consumer ready, no stage may hold back the input.
   a_no_needless_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled although the result side is ready");

   // An item with zero alpha in alpha mode must leave as black.
   a_zero_alpha_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && keep_ff && rsp_alpha_out == 8'h00) |->
      (rsp_red_out == 8'h00 && rsp_green_out == 8'h00 && rsp_blue_out == 8'h00))
      else $error("zero alpha item produced a nonzero color");

   // In plain mode the alpha byte is always cleared.
   a_plain_alpha_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !keep_ff) |-> (rsp_alpha_out == 8'h00))
      else $error("plain mode item carries nonzero alpha");

endmodule
